@@ rtl/tmc_pkg.sv @@
// tmc_pkg: types and constants for the tolerance-match move-to-front tuning cache
// no dependencies; used by the channel interfaces, tmc_khz and the top level
`timescale 1ns / 1ps

package tmc_pkg;

  // payload widths
  localparam int OP_W    = 2;
  localparam int HZ_W    = 26;
  localparam int KHZ_W   = 16;
  localparam int CAP_W   = 7;
  localparam int SLOT_W  = 4;
  localparam int WIN_W   = 16;

  // hz to khz: floor(hz / 1000) as (hz * ceil(2^36 / 1000)) >> 36, exact for 26-bit hz
  localparam int RECIP_W   = 27;
  localparam int KHZ_SHIFT = 36;
  localparam logic [RECIP_W-1:0] KHZ_RECIP = 27'd68719477;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd25;

  // operation codes; code 3 leaves the table alone
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_SAVE   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    logic [KHZ_W-1:0] stored_khz;
    logic [CAP_W-1:0] cap;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_PICK,
    ST_SH_RD,
    ST_SH_WR,
    ST_WR0,
    ST_DONE
  } state_t;

endpackage

@@ rtl/tmc_if.sv @@
// channel interfaces for the tuning cache: request, response and window config
// depends on tmc_pkg for payload widths
`timescale 1ns / 1ps

interface tmc_req_if;
  logic                        valid;
  logic                        ready;
  logic [tmc_pkg::OP_W-1:0]    operation;
  logic [tmc_pkg::HZ_W-1:0]    freq_hz;
  logic [tmc_pkg::CAP_W-1:0]   cap_setting;

  modport source (output valid, output operation, output freq_hz, output cap_setting,
                  input ready);
  modport sink (input valid, input operation, input freq_hz, input cap_setting,
                output ready);
endinterface

interface tmc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [tmc_pkg::SLOT_W-1:0]  slot_index;
  logic [tmc_pkg::CAP_W-1:0]   cap_result;

  modport source (output valid, output hit, output slot_index, output cap_result,
                  input ready);
  modport sink (input valid, input hit, input slot_index, input cap_result,
                output ready);
endinterface

interface tmc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tmc_pkg::WIN_W-1:0]   match_half_window_khz;

  modport source (output valid, output match_half_window_khz, input ready);
  modport sink (input valid, input match_half_window_khz, output ready);
endinterface

@@ rtl/tmc_khz.sv @@
// tmc_khz: hz to khz conversion by reciprocal multiply, one registered stage
// depends on tmc_pkg
`timescale 1ns / 1ps

module tmc_khz (
  input  logic                        clk,
  input  logic [tmc_pkg::HZ_W-1:0]    hz,
  output logic [tmc_pkg::KHZ_W-1:0]   khz
);
  import tmc_pkg::*;

  logic [HZ_W+RECIP_W-1:0] prod;

  // 26 x 27 multiply, product registered
  always_ff @(posedge clk) begin
    prod <= (HZ_W+RECIP_W)'(hz) * (HZ_W+RECIP_W)'(KHZ_RECIP);
  end

  // quotient keeps its low 16 bits
  assign khz = prod[KHZ_SHIFT +: KHZ_W];

endmodule

@@ rtl/tolerance_match_mru_tune_cache.sv @@
// tolerance_match_mru_tune_cache: move-to-front tuning cache with tolerance match
// depends on tmc_pkg, tmc_if (channel interfaces) and tmc_khz
// timing: a lookup scans the table up to the first match before the response,
//   one entry per cycle through the single table read port;
//   a save then shifts the entries above its slot down, one entry per step
// requests: one in flight; the next is accepted in the cycle after the response loads
// reset: synchronous; table reads empty at once (per-entry valid bits), window = 25 khz
`timescale 1ns / 1ps

module tolerance_match_mru_tune_cache #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst,
  tmc_cfg_if.sink   cfg,
  tmc_req_if.sink   req,
  tmc_rsp_if.source rsp
);
  import tmc_pkg::*;

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);
  localparam logic [CW-1:0] NUM_CNT  = CW'(NUM_ENTRIES);

  state_t state, state_next;

  // request registers
  logic [OP_W-1:0]  op_q;
  logic [HZ_W-1:0]  hz_q;
  logic [CAP_W-1:0] cap_q;
  logic [KHZ_W-1:0] khz;
  logic [WIN_W-1:0] window;

  // table storage
  entry_t               mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] vld;
  logic [IW-1:0]        rd_addr;
  entry_t               rd_entry;
  logic                 rd_vld;
  logic                 tbl_we;
  logic [IW-1:0]        tbl_waddr;
  entry_t               tbl_wdata;
  logic                 tbl_wvld;
  logic                 tbl_clr;

  // scan bookkeeping
  logic [CW-1:0]    ptr;
  logic             rd_live;
  logic [IW-1:0]    rd_idx;
  logic             found;
  logic [IW-1:0]    match_idx;
  logic [CAP_W-1:0] match_cap;
  logic             empty_found;
  logic [IW-1:0]    empty_idx;
  logic [IW-1:0]    pick;
  logic [IW-1:0]    save_slot;
  logic [IW-1:0]    sh_ptr;

  // compare unit
  logic             nonempty;
  logic [KHZ_W-1:0] khz_gap;
  logic             hit_now;
  logic             empty_now;

  // response registers
  logic             rsp_vld;
  logic             rsp_hit;
  logic [SLOT_W-1:0] rsp_slot;
  logic [CAP_W-1:0] rsp_cap;
  logic [IW-1:0]    out_idx;
  logic [IW+SLOT_W-1:0] out_idx_ext;
  logic             out_hit;
  logic [CAP_W-1:0] out_cap;
  logic             load_rsp;

  tmc_khz u_khz (
    .clk (clk),
    .hz  (hz_q),
    .khz (khz)
  );

  // window register, always ready
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg.valid) begin
      window <= cfg.match_half_window_khz;
    end
  end

  // shared distance compare on the entry just read
  always_comb begin
    nonempty  = rd_vld && (rd_entry.stored_khz != '0);
    khz_gap   = (rd_entry.stored_khz >= khz) ? (rd_entry.stored_khz - khz)
                                             : (khz - rd_entry.stored_khz);
    hit_now   = rd_live && nonempty && (khz_gap <= window);
    empty_now = rd_live && !nonempty;
  end

  // save slot: match, else first empty, else last
  assign pick = found ? match_idx : (empty_found ? empty_idx : LAST_IDX);

  // sequencer
  always_comb begin
    state_next = state;
    rd_addr    = '0;
    tbl_we     = 1'b0;
    tbl_waddr  = '0;
    tbl_wdata  = '0;
    tbl_wvld   = 1'b0;
    tbl_clr    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.operation)
            OP_LOOKUP, OP_SAVE: state_next = ST_DIV;
            OP_CLEAR: begin
              tbl_clr    = 1'b1;
              state_next = ST_DONE;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_DIV: state_next = ST_SCAN;
      ST_SCAN: begin
        if (ptr < NUM_CNT) begin
          rd_addr = ptr[IW-1:0];
        end
        if (hit_now || (rd_live && rd_idx == LAST_IDX)) begin
          state_next = (op_q == OP_SAVE) ? ST_PICK : ST_DONE;
        end
      end
      ST_PICK: state_next = (pick == '0) ? ST_WR0 : ST_SH_RD;
      ST_SH_RD: begin
        rd_addr    = sh_ptr - 1'b1;
        state_next = ST_SH_WR;
      end
      ST_SH_WR: begin
        tbl_we     = 1'b1;
        tbl_waddr  = sh_ptr;
        tbl_wdata  = rd_entry;
        tbl_wvld   = rd_vld;
        state_next = (sh_ptr == IW'(1)) ? ST_WR0 : ST_SH_RD;
      end
      ST_WR0: begin
        tbl_we     = 1'b1;
        tbl_waddr  = '0;
        tbl_wdata  = '{stored_khz: khz, cap: cap_q};
        tbl_wvld   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_vld || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem[tbl_waddr] <= tbl_wdata;
    end
    rd_entry <= mem[rd_addr];
    rd_vld   <= vld[rd_addr];
  end

  // valid bits; an invalid entry reads as empty
  always_ff @(posedge clk) begin
    if (rst || tbl_clr) begin
      vld <= '0;
    end else if (tbl_we) begin
      vld[tbl_waddr] <= tbl_wvld;
    end
  end

  // scan read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live <= 1'b0;
    end else begin
      rd_live <= (state == ST_SCAN) && (ptr < NUM_CNT);
    end
  end

  // request capture, scan pointer and bookkeeping
  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          op_q  <= req.operation;
          hz_q  <= req.freq_hz;
          cap_q <= req.cap_setting;
        end
      end
      ST_DIV: begin
        ptr         <= '0;
        found       <= 1'b0;
        empty_found <= 1'b0;
      end
      ST_SCAN: begin
        ptr <= ptr + 1'b1;
        if (hit_now) begin
          found     <= 1'b1;
          match_idx <= rd_idx;
          match_cap <= rd_entry.cap;
        end
        if (empty_now && !empty_found) begin
          empty_found <= 1'b1;
          empty_idx   <= rd_idx;
        end
      end
      ST_PICK: begin
        save_slot <= pick;
        sh_ptr    <= pick;
      end
      ST_SH_WR: sh_ptr <= sh_ptr - 1'b1;
      default: ;
    endcase
  end

  // response fields for the finished request
  always_comb begin
    out_idx = '0;
    out_hit = 1'b0;
    out_cap = '0;
    case (op_q)
      OP_LOOKUP: begin
        if (found) begin
          out_hit = 1'b1;
          out_idx = match_idx;
          out_cap = match_cap;
        end
      end
      OP_SAVE: out_idx = save_slot;
      default: ;
    endcase
    out_idx_ext = {{SLOT_W{1'b0}}, out_idx};
  end

  assign load_rsp = (state == ST_DONE) && (!rsp_vld || rsp.ready);

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (load_rsp) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_hit  <= out_hit;
      rsp_slot <= out_idx_ext[SLOT_W-1:0];
      rsp_cap  <= out_cap;
    end
  end

  assign rsp.valid      = rsp_vld;
  assign rsp.hit        = rsp_hit;
  assign rsp.slot_index = rsp_slot;
  assign rsp.cap_result = rsp_cap;

endmodule

@@ sim/tb_tolerance_match_mru_tune_cache.sv @@
// tb_tolerance_match_mru_tune_cache: self-checking bench for the move-to-front tuning cache
// depends on tmc_pkg, the channel interfaces in tmc_if and the tolerance_match_mru_tune_cache top
// a cycle-free mirror of the table predicts every response; a scoreboard checks them in order
`timescale 1ns / 1ps

module tb_tolerance_match_mru_tune_cache;
  import tmc_pkg::*;

  localparam int NUM_ENTRIES = 16;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * NUM_ENTRIES + 8;
  localparam int POOL_SIZE = 20;
  localparam int HOLD_CYCLES = 300;
  localparam logic [HZ_W-1:0] HZ_MAX = '1;
  localparam longint HZ_TOP = 64'd67108863;
  localparam int HZ_PER_KHZ = 1000;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [CAP_W-1:0]  cap;
  } tune_rsp_t;

  logic clk = 1'b0;
  logic rst;

  tmc_cfg_if cfg_if();
  tmc_req_if req_if();
  tmc_rsp_if rsp_if();

  tolerance_match_mru_tune_cache #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_dut (
    .clk,
    .rst,
    .cfg(cfg_if),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #5 clk = ~clk;

  // mirror of the cache contents and the match window
  logic [KHZ_W-1:0] mirror_khz [NUM_ENTRIES];
  logic [CAP_W-1:0] mirror_cap [NUM_ENTRIES];
  logic [WIN_W-1:0] mirror_window;

  tune_rsp_t   expected_rsp_q[$];
  int          mismatch_count = 0;
  int          req_idle_pct = 25;
  int          rsp_idle_pct = 20;
  int          rsp_hold_cycles = 0;
  int          quiet_cycles = 0;
  int unsigned chan_khz [POOL_SIZE];

  function automatic void mirror_clear();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      mirror_khz[i] = '0;
      mirror_cap[i] = '0;
    end
  endfunction

  // first non-empty entry within the window, -1 when none
  function automatic int find_tuned_slot(logic [KHZ_W-1:0] khz);
    int khz_gap;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (mirror_khz[i] == '0) continue;
      khz_gap = (mirror_khz[i] >= khz) ? int'(mirror_khz[i]) - int'(khz)
                                       : int'(khz) - int'(mirror_khz[i]);
      if (khz_gap <= int'(mirror_window)) return i;
    end
    return -1;
  endfunction

  // apply one request to the mirror and return the response it should produce
  function automatic tune_rsp_t predict_tune(logic [OP_W-1:0] op, logic [HZ_W-1:0] hz,
                                             logic [CAP_W-1:0] cap);
    tune_rsp_t   rsp;
    int unsigned khz_full;
    logic [KHZ_W-1:0] khz;
    int slot;
    rsp = '0;
    khz_full = hz / HZ_PER_KHZ;
    khz = khz_full[KHZ_W-1:0];
    case (op)
      OP_LOOKUP: begin
        slot = find_tuned_slot(khz);
        if (slot >= 0) begin
          rsp.hit  = 1'b1;
          rsp.slot = slot[SLOT_W-1:0];
          rsp.cap  = mirror_cap[slot];
        end
      end
      OP_SAVE: begin
        slot = find_tuned_slot(khz);
        if (slot < 0) begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (mirror_khz[i] == '0) begin
              slot = i;
              break;
            end
          end
          if (slot < 0) slot = NUM_ENTRIES - 1;
        end
        // entries above the chosen slot move down, new pair goes to the front
        for (int i = slot; i > 0; i--) begin
          mirror_khz[i] = mirror_khz[i-1];
          mirror_cap[i] = mirror_cap[i-1];
        end
        mirror_khz[0] = khz;
        mirror_cap[0] = cap;
        rsp.slot = slot[SLOT_W-1:0];
      end
      OP_CLEAR: mirror_clear();
      default: ;
    endcase
    return rsp;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  // response scoreboard
  always @(posedge clk) begin : rsp_check
    tune_rsp_t exp_rsp;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_rsp_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: response with none expected: hit %0b slot %0d cap %0d", $time,
                 rsp_if.hit, rsp_if.slot_index, rsp_if.cap_result);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (rsp_if.hit !== exp_rsp.hit) begin
          mismatch_count++;
          $display("%0t: hit expected %0b got %0b", $time, exp_rsp.hit, rsp_if.hit);
        end
        if (rsp_if.slot_index !== exp_rsp.slot) begin
          mismatch_count++;
          $display("%0t: slot_index expected %0d got %0d", $time, exp_rsp.slot,
                   rsp_if.slot_index);
        end
        if (rsp_if.cap_result !== exp_rsp.cap) begin
          mismatch_count++;
          $display("%0t: cap_result expected %0d got %0d", $time, exp_rsp.cap,
                   rsp_if.cap_result);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst === 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // response side: random stalls plus an occasional long hold-off
  initial begin : rsp_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_cycles > 0) begin
        hold_left = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < rsp_idle_pct) stall_left = pick_gap();
      end
    end
  end

  // one request transfer, prediction at acceptance, then maybe a gap
  task automatic send_item(logic [OP_W-1:0] op, logic [HZ_W-1:0] hz, logic [CAP_W-1:0] cap);
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.freq_hz     <= hz;
    req_if.cap_setting <= cap;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    expected_rsp_q.push_back(predict_tune(op, hz, cap));
    if ($urandom_range(0, 99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding response
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(logic [WIN_W-1:0] window);
    drain_responses();
    cfg_if.valid                 <= 1'b1;
    cfg_if.match_half_window_khz <= window;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    mirror_window = window;
  endtask

  // channel frequencies for one phase, a couple pinned near the ends of the range
  task automatic new_channel_pool();
    for (int k = 0; k < POOL_SIZE; k++) chan_khz[k] = $urandom_range(1, 67108);
    chan_khz[0] = $urandom_range(1, 30);
    chan_khz[1] = $urandom_range(65500, 67108);
  endtask

  // mostly near-channel lookups and saves, some clears, reserved codes and raw noise
  task automatic send_random_item();
    int pick;
    int span;
    int offset;
    longint hz;
    logic [OP_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 48) op = OP_LOOKUP;
    else if (pick < 92) op = OP_SAVE;
    else if (pick < 95) op = OP_CLEAR;
    else op = OP_RESERVED;
    if ($urandom_range(0, 9) == 0) begin
      hz = longint'(HZ_W'($urandom()));
    end else begin
      span = (mirror_window > 200) ? 200 : int'(mirror_window) + 2;
      offset = $urandom_range(0, 2 * span) - span;
      hz = (longint'(chan_khz[$urandom_range(0, POOL_SIZE - 1)]) + offset) * HZ_PER_KHZ
           + longint'($urandom_range(0, HZ_PER_KHZ - 1));
      if (hz < 0) hz = 0;
      if (hz > HZ_TOP) hz = HZ_TOP;
    end
    send_item(op, hz[HZ_W-1:0], CAP_W'($urandom_range(0, 127)));
  endtask

  // edges of the window, zero khz saves, wrap above range, reserved code
  task automatic test_lookup_save_basics();
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_RESERVED, HZ_MAX, '1);
    send_item(OP_CLEAR, 26'd12345, 7'd9);
    send_item(OP_SAVE, 26'd7_000_000, 7'h7F);
    send_item(OP_LOOKUP, 26'd7_025_999, '0);
    send_item(OP_LOOKUP, 26'd7_026_000, '0);
    send_item(OP_LOOKUP, 26'd6_975_000, '0);
    send_item(OP_SAVE, 26'd14_200_000, 7'd0);
    // matches the older entry and moves it to the front
    send_item(OP_SAVE, 26'd7_010_500, 7'd5);
    // zero khz entry reads as empty afterwards
    send_item(OP_SAVE, 26'd999, 7'd55);
    send_item(OP_LOOKUP, 26'd0, '0);
    send_item(OP_SAVE, 26'd21_000_000, 7'd33);
    // top of the hz range wraps in khz
    send_item(OP_SAVE, HZ_MAX, 7'h2A);
    send_item(OP_LOOKUP, 26'd1_572_000, '0);
    send_item(OP_SAVE, 26'd65_535_999, 7'd1);
    send_item(OP_LOOKUP, 26'd65_535_000, '0);
    send_item(OP_RESERVED, 26'd7_000_000, 7'd3);
    send_item(OP_LOOKUP, 26'd7_000_000, '0);
  endtask

  // fill every slot, then force eviction of the last one
  task automatic test_full_table();
    send_item(OP_CLEAR, '0, '0);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      send_item(OP_SAVE, HZ_W'((1000 + 200 * i) * HZ_PER_KHZ), CAP_W'(i + 1));
    end
    send_item(OP_LOOKUP, 26'd1_600_000, '0);
    send_item(OP_SAVE, 26'd50_000_000, 7'd100);
    send_item(OP_LOOKUP, 26'd1_000_000, '0);
  endtask

  // exact-only match, then a window that covers everything
  task automatic test_window_extremes();
    write_window('0);
    send_item(OP_SAVE, 26'd30_000_000, 7'd11);
    send_item(OP_LOOKUP, 26'd30_000_999, '0);
    send_item(OP_LOOKUP, 26'd30_001_000, '0);
    write_window('1);
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_LOOKUP, HZ_MAX, '0);
  endtask

  task automatic test_random_phase(logic [WIN_W-1:0] window, int count, int idle_pct);
    write_window(window);
    new_channel_pool();
    req_idle_pct = idle_pct;
    rsp_idle_pct = idle_pct;
    repeat (count) send_random_item();
  endtask

  // receiver holds off while requests keep coming, then the sender waits for all
  task automatic test_receiver_hold();
    drain_responses();
    req_idle_pct = 0;
    rsp_hold_cycles = HOLD_CYCLES;
    repeat (10) send_random_item();
    drain_responses();
  endtask

  initial begin
    rst                          <= 1'b1;
    req_if.valid                 <= 1'b0;
    req_if.operation             <= '0;
    req_if.freq_hz               <= '0;
    req_if.cap_setting           <= '0;
    cfg_if.valid                 <= 1'b0;
    cfg_if.match_half_window_khz <= '0;
    mirror_clear();
    mirror_window = WINDOW_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_lookup_save_basics();
    test_full_table();
    test_window_extremes();
    test_random_phase(16'd25, 170, 25);
    test_random_phase('0, 70, 25);
    test_random_phase('1, 60, 30);
    test_random_phase(WIN_W'($urandom_range(1, 4000)), 100, 0);
    test_receiver_hold();
    test_random_phase(WIN_W'($urandom_range(26, 300)), 80, 40);

    // let any stray response show up before the verdict
    drain_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
